// ----- rtl/assert_macros.svh -----
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/efsm_pkg.sv -----
package efsm_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int WIDE_W     = 64;
   localparam int GAMMA_W    = 18;
   localparam int MAG_W      = 31;

   localparam int DEN_W      = GAMMA_W + MAG_W;
   localparam int NUM_W      = DEN_W + FRAC_BITS;
   localparam int DIV_BITS   = 2;
   localparam int DIV_STAGES = (NUM_W + DIV_BITS - 1) / DIV_BITS;
   localparam int DVD_W      = DIV_STAGES * DIV_BITS;
   localparam int DIV_LAT    = DIV_STAGES + 1;
   localparam int MUL_LAT    = 4;

   typedef logic signed [WIDE_W-1:0]     wide_type;
   typedef logic signed [DATA_WIDTH-1:0] data_type;

   localparam logic [GAMMA_W-1:0] HEAT_RATIO_RST = GAMMA_W'(91750);
   localparam logic [GAMMA_W-1:0] ONE_Q          = GAMMA_W'(1 << FRAC_BITS);

   localparam wide_type WIDE_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
   localparam wide_type WIDE_MIN = {1'b1, {(WIDE_W-1){1'b0}}};
   localparam wide_type DATA_MAX = {{(WIDE_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
   localparam wide_type DATA_MIN = ~DATA_MAX;

   function automatic wide_type sadd(input wide_type a, input wide_type b);
      logic [WIDE_W:0] s;
      s = {a[WIDE_W-1], a} + {b[WIDE_W-1], b};
      if (s[WIDE_W] != s[WIDE_W-1]) begin
         sadd = s[WIDE_W] ? WIDE_MIN : WIDE_MAX;
      end else begin
         sadd = s[WIDE_W-1:0];
      end
   endfunction

   function automatic wide_type ssub(input wide_type a, input wide_type b);
      logic [WIDE_W:0] s;
      s = {a[WIDE_W-1], a} - {b[WIDE_W-1], b};
      if (s[WIDE_W] != s[WIDE_W-1]) begin
         ssub = s[WIDE_W] ? WIDE_MIN : WIDE_MAX;
      end else begin
         ssub = s[WIDE_W-1:0];
      end
   endfunction

   // halve, rounding toward zero
   function automatic wide_type half(input wide_type x);
      wide_type t;
      t = x + {{(WIDE_W-1){1'b0}}, x[WIDE_W-1]};
      half = t >>> 1;
   endfunction

   function automatic data_type clamp(input wide_type x);
      wide_type c;
      if (x > DATA_MAX) begin
         c = DATA_MAX;
      end else if (x < DATA_MIN) begin
         c = DATA_MIN;
      end else begin
         c = x;
      end
      clamp = c[DATA_WIDTH-1:0];
   endfunction

endpackage

// ----- rtl/efsm_mul.sv -----
module efsm_mul (
   input  logic              clock,
   input  logic              en,
   input  efsm_pkg::wide_type op_a,
   input  efsm_pkg::wide_type op_b,
   output efsm_pkg::wide_type prod
);
   import efsm_pkg::*;

   localparam int HW = WIDE_W / 2;

   logic [WIDE_W-1:0]   ma_in, mb_in, ma_ff, mb_ff;
   logic                neg1_ff, neg2_ff, neg3_ff;
   logic [WIDE_W-1:0]   p00_ff, p01_ff, p10_ff, p11_ff;
   logic [2*WIDE_W-1:0] sum_in, sum_ff, sh;
   wide_type            prod_in, prod_ff;

   always_comb begin
      ma_in = op_a[WIDE_W-1] ? (~op_a + 1'b1) : op_a;
      mb_in = op_b[WIDE_W-1] ? (~op_b + 1'b1) : op_b;
      sum_in = {{WIDE_W{1'b0}}, p00_ff}
             + {{HW{1'b0}}, p01_ff, {HW{1'b0}}}
             + {{HW{1'b0}}, p10_ff, {HW{1'b0}}}
             + {p11_ff, {WIDE_W{1'b0}}};
      sh = sum_ff >> FRAC_BITS;
      if (|sh[2*WIDE_W-1:WIDE_W-1]) begin
         prod_in = neg3_ff ? WIDE_MIN : WIDE_MAX;
      end else if (neg3_ff) begin
         prod_in = -sh[WIDE_W-1:0];
      end else begin
         prod_in = sh[WIDE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff   <= ma_in;
         mb_ff   <= mb_in;
         neg1_ff <= op_a[WIDE_W-1] ^ op_b[WIDE_W-1];
         p00_ff  <= WIDE_W'(ma_ff[HW-1:0]) * WIDE_W'(mb_ff[HW-1:0]);
         p01_ff  <= WIDE_W'(ma_ff[HW-1:0]) * WIDE_W'(mb_ff[WIDE_W-1:HW]);
         p10_ff  <= WIDE_W'(ma_ff[WIDE_W-1:HW]) * WIDE_W'(mb_ff[HW-1:0]);
         p11_ff  <= WIDE_W'(ma_ff[WIDE_W-1:HW]) * WIDE_W'(mb_ff[WIDE_W-1:HW]);
         neg2_ff <= neg1_ff;
         sum_ff  <= sum_in;
         neg3_ff <= neg2_ff;
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// ----- rtl/efsm_div.sv -----
module efsm_div (
   input  logic                          clock,
   input  logic                          en,
   input  logic [efsm_pkg::NUM_W-1:0]    dvd_in,
   input  logic [efsm_pkg::DEN_W-1:0]    dvs_in,
   output efsm_pkg::wide_type            quo_out
);
   import efsm_pkg::*;

   logic [DEN_W-1:0] rem_cur [DIV_STAGES];
   logic [DVD_W-1:0] dvd_cur [DIV_STAGES];
   logic [DVD_W-1:0] quo_cur [DIV_STAGES];
   logic [DEN_W-1:0] dvs_cur [DIV_STAGES];
   logic [DEN_W-1:0] rem_in  [DIV_STAGES];
   logic [DVD_W-1:0] dvd_in_s [DIV_STAGES];
   logic [DVD_W-1:0] quo_in  [DIV_STAGES];
   logic [DEN_W-1:0] rem_ff  [1:DIV_STAGES];
   logic [DVD_W-1:0] dvd_ff  [1:DIV_STAGES];
   logic [DVD_W-1:0] quo_ff  [1:DIV_STAGES];
   logic [DEN_W-1:0] dvs_ff  [1:DIV_STAGES];
   wide_type         res_in, res_ff;

   always_comb begin
      rem_cur[0] = '0;
      dvd_cur[0] = DVD_W'(dvd_in);
      quo_cur[0] = '0;
      dvs_cur[0] = dvs_in;
      for (int g = 1; g < DIV_STAGES; g++) begin
         rem_cur[g] = rem_ff[g];
         dvd_cur[g] = dvd_ff[g];
         quo_cur[g] = quo_ff[g];
         dvs_cur[g] = dvs_ff[g];
      end
   end

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
      always_comb begin
         logic [DEN_W-1:0] r;
         logic [DEN_W:0]   t;
         logic [DVD_W-1:0] d;
         logic [DVD_W-1:0] q;
         r = rem_cur[g];
         d = dvd_cur[g];
         q = quo_cur[g];
         for (int b = 0; b < DIV_BITS; b++) begin
            t = {r, d[DVD_W-1]};
            d = d << 1;
            if (t >= {1'b0, dvs_cur[g]}) begin
               t = t - {1'b0, dvs_cur[g]};
               q = {q[DVD_W-2:0], 1'b1};
            end else begin
               q = {q[DVD_W-2:0], 1'b0};
            end
            r = t[DEN_W-1:0];
         end
         rem_in[g]   = r;
         dvd_in_s[g] = d;
         quo_in[g]   = q;
      end
   end

   always_comb begin
      if (|quo_ff[DIV_STAGES][DVD_W-1:WIDE_W-1]) begin
         res_in = WIDE_MAX;
      end else begin
         res_in = wide_type'(quo_ff[DIV_STAGES][WIDE_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int g = 0; g < DIV_STAGES; g++) begin
            rem_ff[g+1] <= rem_in[g];
            dvd_ff[g+1] <= dvd_in_s[g];
            quo_ff[g+1] <= quo_in[g];
            dvs_ff[g+1] <= dvs_cur[g];
         end
         res_ff <= res_in;
      end
   end

   assign quo_out = res_ff;

endmodule

// ----- rtl/euler_flux_split_matvec.sv -----
// channel | direction | handshake             | word
// req     | in        | req_valid / req_ready | gas state, normal, lambda, sign, increment
// rsp     | out       | rsp_valid / rsp_ready | four saturated result components
// csr     | in        | csr_valid / csr_ready | heat ratio, taken at once
// one word enters per cycle unless the pipe is frozen
// the enthalpy divider resolves two quotient bits per stage
// the whole pipe freezes while the last stage holds a word not yet taken
// reset clears the valid bits and loads the default heat ratio
`include "assert_macros.svh"

module euler_flux_split_matvec (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [efsm_pkg::MAG_W-1:0]        req_density,
   input  efsm_pkg::data_type                req_vel_x,
   input  efsm_pkg::data_type                req_vel_y,
   input  logic [efsm_pkg::MAG_W-1:0]        req_pressure,
   input  efsm_pkg::data_type                req_normal_x,
   input  efsm_pkg::data_type                req_normal_y,
   input  logic [efsm_pkg::MAG_W-1:0]        req_spectral_radius,
   input  logic                              req_minus_split,
   input  efsm_pkg::data_type                req_incr_mass,
   input  efsm_pkg::data_type                req_incr_mom_x,
   input  efsm_pkg::data_type                req_incr_mom_y,
   input  efsm_pkg::data_type                req_incr_energy,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output efsm_pkg::data_type                rsp_out_mass,
   output efsm_pkg::data_type                rsp_out_mom_x,
   output efsm_pkg::data_type                rsp_out_mom_y,
   output efsm_pkg::data_type                rsp_out_energy,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [efsm_pkg::GAMMA_W-1:0]      csr_heat_ratio
);
   import efsm_pkg::*;

   localparam int T_M1  = MUL_LAT;
   localparam int T_B   = T_M1 + 1;
   localparam int T_M2  = T_B + MUL_LAT;
   localparam int T_C   = T_M2 + 1;
   localparam int T_M3  = T_C + MUL_LAT;
   localparam int T_D   = T_M3 + 1;
   localparam int T_DIV = 1 + DIV_LAT;
   localparam int T_H   = T_DIV + 1;
   localparam int T_TH  = T_H + 1;
   localparam int T_A   = T_TH + MUL_LAT;
   localparam int T_P   = T_A + MUL_LAT;
   localparam int T_S3  = T_P + 3;
   localparam int T_OUT = T_P + 5;

   localparam int M_UU   = 0;
   localparam int M_VV   = 1;
   localparam int M_UNX  = 2;
   localparam int M_VNY  = 3;
   localparam int M_UNY  = 4;
   localparam int M_VNX  = 5;
   localparam int M_GNX  = 6;
   localparam int M_GNY  = 7;
   localparam int M_GU   = 8;
   localparam int M_GV   = 9;
   localparam int M_LX   = 10;
   localparam int M_GQ2  = 14;
   localparam int M_UUN  = 15;
   localparam int M_VUN  = 16;
   localparam int M_GUN  = 17;
   localparam int M_GVN  = 18;
   localparam int M_A33  = 19;
   localparam int M_GNXU = 20;
   localparam int M_GNXV = 21;
   localparam int M_GNYU = 22;
   localparam int M_GNYV = 23;
   localparam int M_NXTH = 24;
   localparam int M_NYTH = 25;
   localparam int M_NXH  = 26;
   localparam int M_NYH  = 27;
   localparam int M_A30  = 28;
   localparam int M_PR   = 29;
   localparam int NMUL   = M_PR + 16;

   logic               adv;
   logic [GAMMA_W-1:0] heat_ratio_ff, gm1;
   logic [MAG_W-1:0]   rho_eff;
   logic               vld_ff [0:T_OUT];

   data_type           x_in [4];
   data_type           u_ff [0:T_B];
   data_type           v_ff [0:T_B];
   data_type           nx_ff [0:T_A];
   data_type           ny_ff [0:T_A];
   data_type           x_ff [4][0:T_A];
   logic               mns_ff [0:T_S3];
   logic [MAG_W-1:0]   rho_ff, p_ff, lam_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [DEN_W-1:0]   den_ff;
   wide_type           quo;

   wide_type           mul_a [NMUL];
   wide_type           mul_b [NMUL];
   wide_type           mul_p [NMUL];

   wide_type           unx_ff, vny_ff, gu_ff, gv_ff;
   wide_type           q2_ff [T_B:T_H-1];
   wide_type           un_ff [T_B:T_TH];
   wide_type           uny_ff [T_B:T_M2];
   wide_type           vnx_ff [T_B:T_M2];
   wide_type           gnx_ff [T_B:T_A];
   wide_type           gny_ff [T_B:T_A];
   wide_type           lx_ff [4][T_B:T_S3];
   wide_type           s11_ff [T_B+1:T_M2];
   wide_type           s22_ff [T_B+1:T_M2];
   wide_type           theta_ff [T_C:T_H];
   wide_type           a11_ff [T_C:T_A];
   wide_type           a12_ff [T_C:T_A];
   wide_type           a21_ff [T_C:T_A];
   wide_type           a22_ff [T_C:T_A];
   wide_type           a33_ff [T_C:T_A];
   wide_type           nuun_ff [T_C:T_M3];
   wide_type           nvun_ff [T_C:T_M3];
   wide_type           gun_ff [T_C:T_A-1];
   wide_type           gvn_ff [T_C:T_A-1];
   wide_type           a10_ff [T_D:T_A];
   wide_type           a20_ff [T_D:T_A];
   wide_type           h_ff, th_ff, a31_ff, a32_ff;
   wide_type           am [4][4];
   wide_type           sa_ff [4];
   wide_type           sb_ff [4];
   wide_type           sc_ff [4];
   wide_type           p2_ff [4];
   wide_type           p3a_ff [4];
   wide_type           p3b_ff [4];
   wide_type           yt_ff [4];
   data_type           out_ff [4];

   assign adv       = !vld_ff[T_OUT] || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;
   assign rsp_valid = vld_ff[T_OUT];

   assign rsp_out_mass   = out_ff[0];
   assign rsp_out_mom_x  = out_ff[1];
   assign rsp_out_mom_y  = out_ff[2];
   assign rsp_out_energy = out_ff[3];

   always_comb begin
      gm1 = (heat_ratio_ff > ONE_Q) ? (heat_ratio_ff - ONE_Q) : GAMMA_W'(1);
      rho_eff = (rho_ff == '0) ? MAG_W'(1) : rho_ff;
      x_in[0] = req_incr_mass;
      x_in[1] = req_incr_mom_x;
      x_in[2] = req_incr_mom_y;
      x_in[3] = req_incr_energy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heat_ratio_ff <= HEAT_RATIO_RST;
      end else if (csr_valid) begin
         heat_ratio_ff <= csr_heat_ratio;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= T_OUT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k <= T_OUT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // multiplier operands
   always_comb begin
      mul_a[M_UU]   = wide_type'(u_ff[0]);
      mul_b[M_UU]   = wide_type'(u_ff[0]);
      mul_a[M_VV]   = wide_type'(v_ff[0]);
      mul_b[M_VV]   = wide_type'(v_ff[0]);
      mul_a[M_UNX]  = wide_type'(u_ff[0]);
      mul_b[M_UNX]  = wide_type'(nx_ff[0]);
      mul_a[M_VNY]  = wide_type'(v_ff[0]);
      mul_b[M_VNY]  = wide_type'(ny_ff[0]);
      mul_a[M_UNY]  = wide_type'(u_ff[0]);
      mul_b[M_UNY]  = wide_type'(ny_ff[0]);
      mul_a[M_VNX]  = wide_type'(v_ff[0]);
      mul_b[M_VNX]  = wide_type'(nx_ff[0]);
      mul_a[M_GNX]  = wide_type'(nx_ff[0]);
      mul_b[M_GNX]  = wide_type'(gm1);
      mul_a[M_GNY]  = wide_type'(ny_ff[0]);
      mul_b[M_GNY]  = wide_type'(gm1);
      mul_a[M_GU]   = wide_type'(gm1);
      mul_b[M_GU]   = wide_type'(u_ff[0]);
      mul_a[M_GV]   = wide_type'(gm1);
      mul_b[M_GV]   = wide_type'(v_ff[0]);
      for (int i = 0; i < 4; i++) begin
         mul_a[M_LX+i] = wide_type'(lam_ff);
         mul_b[M_LX+i] = wide_type'(x_ff[i][0]);
      end
      mul_a[M_GQ2]  = wide_type'(gm1);
      mul_b[M_GQ2]  = q2_ff[T_B];
      mul_a[M_UUN]  = wide_type'(u_ff[T_B]);
      mul_b[M_UUN]  = un_ff[T_B];
      mul_a[M_VUN]  = wide_type'(v_ff[T_B]);
      mul_b[M_VUN]  = un_ff[T_B];
      mul_a[M_GUN]  = gu_ff;
      mul_b[M_GUN]  = un_ff[T_B];
      mul_a[M_GVN]  = gv_ff;
      mul_b[M_GVN]  = un_ff[T_B];
      mul_a[M_A33]  = wide_type'(heat_ratio_ff);
      mul_b[M_A33]  = un_ff[T_B];
      mul_a[M_GNXU] = gnx_ff[T_B];
      mul_b[M_GNXU] = wide_type'(u_ff[T_B]);
      mul_a[M_GNXV] = gnx_ff[T_B];
      mul_b[M_GNXV] = wide_type'(v_ff[T_B]);
      mul_a[M_GNYU] = gny_ff[T_B];
      mul_b[M_GNYU] = wide_type'(u_ff[T_B]);
      mul_a[M_GNYV] = gny_ff[T_B];
      mul_b[M_GNYV] = wide_type'(v_ff[T_B]);
      mul_a[M_NXTH] = wide_type'(nx_ff[T_C]);
      mul_b[M_NXTH] = theta_ff[T_C];
      mul_a[M_NYTH] = wide_type'(ny_ff[T_C]);
      mul_b[M_NYTH] = theta_ff[T_C];
      mul_a[M_NXH]  = wide_type'(nx_ff[T_H]);
      mul_b[M_NXH]  = h_ff;
      mul_a[M_NYH]  = wide_type'(ny_ff[T_H]);
      mul_b[M_NYH]  = h_ff;
      mul_a[M_A30]  = un_ff[T_TH];
      mul_b[M_A30]  = th_ff;

      am[0][0] = '0;
      am[0][1] = wide_type'(nx_ff[T_A]);
      am[0][2] = wide_type'(ny_ff[T_A]);
      am[0][3] = '0;
      am[1][0] = a10_ff[T_A];
      am[1][1] = a11_ff[T_A];
      am[1][2] = a12_ff[T_A];
      am[1][3] = gnx_ff[T_A];
      am[2][0] = a20_ff[T_A];
      am[2][1] = a21_ff[T_A];
      am[2][2] = a22_ff[T_A];
      am[2][3] = gny_ff[T_A];
      am[3][0] = mul_p[M_A30];
      am[3][1] = a31_ff;
      am[3][2] = a32_ff;
      am[3][3] = a33_ff[T_A];
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            mul_a[M_PR+4*i+j] = am[i][j];
            mul_b[M_PR+4*i+j] = wide_type'(x_ff[j][T_A]);
         end
      end
   end

   for (genvar m = 0; m < NMUL; m++) begin : g_mul
      efsm_mul u_mul (
         .clock (clock),
         .en    (adv),
         .op_a  (mul_a[m]),
         .op_b  (mul_b[m]),
         .prod  (mul_p[m])
      );
   end

   efsm_div u_div (
      .clock   (clock),
      .en      (adv),
      .dvd_in  (num_ff),
      .dvs_in  (den_ff),
      .quo_out (quo)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         // input stage
         u_ff[0]   <= req_vel_x;
         v_ff[0]   <= req_vel_y;
         nx_ff[0]  <= req_normal_x;
         ny_ff[0]  <= req_normal_y;
         mns_ff[0] <= req_minus_split;
         rho_ff    <= req_density;
         p_ff      <= req_pressure;
         lam_ff    <= req_spectral_radius;
         for (int i = 0; i < 4; i++) begin
            x_ff[i][0] <= x_in[i];
            for (int k = 1; k <= T_A; k++) begin
               x_ff[i][k] <= x_ff[i][k-1];
            end
         end
         for (int k = 1; k <= T_B; k++) begin
            u_ff[k] <= u_ff[k-1];
            v_ff[k] <= v_ff[k-1];
         end
         for (int k = 1; k <= T_A; k++) begin
            nx_ff[k] <= nx_ff[k-1];
            ny_ff[k] <= ny_ff[k-1];
         end
         for (int k = 1; k <= T_S3; k++) begin
            mns_ff[k] <= mns_ff[k-1];
         end

         // enthalpy quotient operands
         num_ff <= {DEN_W'(heat_ratio_ff) * DEN_W'(p_ff), {FRAC_BITS{1'b0}}};
         den_ff <= DEN_W'(gm1) * DEN_W'(rho_eff);

         // speed terms
         q2_ff[T_B] <= sadd(mul_p[M_UU], mul_p[M_VV]);
         un_ff[T_B] <= sadd(mul_p[M_UNX], mul_p[M_VNY]);
         unx_ff     <= mul_p[M_UNX];
         vny_ff     <= mul_p[M_VNY];
         gu_ff      <= mul_p[M_GU];
         gv_ff      <= mul_p[M_GV];
         uny_ff[T_B] <= mul_p[M_UNY];
         vnx_ff[T_B] <= mul_p[M_VNX];
         gnx_ff[T_B] <= mul_p[M_GNX];
         gny_ff[T_B] <= mul_p[M_GNY];
         for (int i = 0; i < 4; i++) begin
            lx_ff[i][T_B] <= mul_p[M_LX+i];
            for (int k = T_B + 1; k <= T_S3; k++) begin
               lx_ff[i][k] <= lx_ff[i][k-1];
            end
         end
         for (int k = T_B + 1; k <= T_H - 1; k++) begin
            q2_ff[k] <= q2_ff[k-1];
         end
         for (int k = T_B + 1; k <= T_TH; k++) begin
            un_ff[k] <= un_ff[k-1];
         end
         for (int k = T_B + 1; k <= T_M2; k++) begin
            uny_ff[k] <= uny_ff[k-1];
            vnx_ff[k] <= vnx_ff[k-1];
         end
         for (int k = T_B + 1; k <= T_A; k++) begin
            gnx_ff[k] <= gnx_ff[k-1];
            gny_ff[k] <= gny_ff[k-1];
         end
         s11_ff[T_B+1] <= sadd(un_ff[T_B], unx_ff);
         s22_ff[T_B+1] <= sadd(un_ff[T_B], vny_ff);
         for (int k = T_B + 2; k <= T_M2; k++) begin
            s11_ff[k] <= s11_ff[k-1];
            s22_ff[k] <= s22_ff[k-1];
         end

         // jacobian entries, velocity rows and the energy-row diagonal
         theta_ff[T_C] <= half(mul_p[M_GQ2]);
         a11_ff[T_C]   <= ssub(s11_ff[T_M2], mul_p[M_GNXU]);
         a12_ff[T_C]   <= ssub(uny_ff[T_M2], mul_p[M_GNXV]);
         a21_ff[T_C]   <= ssub(vnx_ff[T_M2], mul_p[M_GNYU]);
         a22_ff[T_C]   <= ssub(s22_ff[T_M2], mul_p[M_GNYV]);
         a33_ff[T_C]   <= mul_p[M_A33];
         nuun_ff[T_C]  <= ssub('0, mul_p[M_UUN]);
         nvun_ff[T_C]  <= ssub('0, mul_p[M_VUN]);
         gun_ff[T_C]   <= mul_p[M_GUN];
         gvn_ff[T_C]   <= mul_p[M_GVN];
         for (int k = T_C + 1; k <= T_H; k++) begin
            theta_ff[k] <= theta_ff[k-1];
         end
         for (int k = T_C + 1; k <= T_A; k++) begin
            a11_ff[k] <= a11_ff[k-1];
            a12_ff[k] <= a12_ff[k-1];
            a21_ff[k] <= a21_ff[k-1];
            a22_ff[k] <= a22_ff[k-1];
            a33_ff[k] <= a33_ff[k-1];
         end
         for (int k = T_C + 1; k <= T_M3; k++) begin
            nuun_ff[k] <= nuun_ff[k-1];
            nvun_ff[k] <= nvun_ff[k-1];
         end
         for (int k = T_C + 1; k <= T_A - 1; k++) begin
            gun_ff[k] <= gun_ff[k-1];
            gvn_ff[k] <= gvn_ff[k-1];
         end
         a10_ff[T_D] <= sadd(nuun_ff[T_M3], mul_p[M_NXTH]);
         a20_ff[T_D] <= sadd(nvun_ff[T_M3], mul_p[M_NYTH]);
         for (int k = T_D + 1; k <= T_A; k++) begin
            a10_ff[k] <= a10_ff[k-1];
            a20_ff[k] <= a20_ff[k-1];
         end

         // energy row
         h_ff   <= sadd(quo, half(q2_ff[T_H-1]));
         th_ff  <= ssub(theta_ff[T_H], h_ff);
         a31_ff <= ssub(mul_p[M_NXH], gun_ff[T_A-1]);
         a32_ff <= ssub(mul_p[M_NYH], gvn_ff[T_A-1]);

         // row sums, split term and output
         for (int i = 0; i < 4; i++) begin
            sa_ff[i]  <= sadd(mul_p[M_PR+4*i], mul_p[M_PR+4*i+1]);
            p2_ff[i]  <= mul_p[M_PR+4*i+2];
            p3a_ff[i] <= mul_p[M_PR+4*i+3];
            sb_ff[i]  <= sadd(sa_ff[i], p2_ff[i]);
            p3b_ff[i] <= p3a_ff[i];
            sc_ff[i]  <= sadd(sb_ff[i], p3b_ff[i]);
            yt_ff[i]  <= mns_ff[T_S3] ? ssub(sc_ff[i], lx_ff[i][T_S3])
                                      : sadd(sc_ff[i], lx_ff[i][T_S3]);
            out_ff[i] <= clamp(half(yt_ff[i]));
         end
      end
   end

   `ASSERT_IMPL(a_stall_blocks_req, clock, reset, rsp_valid && !rsp_ready, !req_ready, "pipe took a word during output stall")
   `ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && req_ready, vld_ff[0], "accepted word missing from first stage")
   `ASSERT_NEXT(a_last_stage, clock, reset, adv && vld_ff[T_OUT-1], rsp_valid, "word lost before output register")

endmodule

// ----- sim/euler_flux_split_matvec_test.sv -----
`timescale 1ns / 100ps

module euler_flux_split_matvec_test;
   import efsm_pkg::*;

   localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint I64_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
   localparam longint Q_ONE   = 64'sd1 << FRAC_BITS;
   localparam int     CYCLE_LIMIT = 600000;
   localparam int     DRAIN_CYCLES = 80;
   localparam int     HOLD_CYCLES = 400;

   typedef struct {
      logic [MAG_W-1:0] density;
      data_type         vel_x, vel_y;
      logic [MAG_W-1:0] pressure;
      data_type         normal_x, normal_y;
      logic [MAG_W-1:0] spectral_radius;
      logic             minus_split;
      data_type         incr [4];
   } face_type;

   typedef struct {
      data_type flux [4];
   } flux_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [MAG_W-1:0] req_density = '0, req_pressure = '0, req_spectral_radius = '0;
   data_type req_vel_x = '0, req_vel_y = '0, req_normal_x = '0, req_normal_y = '0;
   logic req_minus_split = 0;
   data_type req_incr_mass = '0, req_incr_mom_x = '0, req_incr_mom_y = '0;
   data_type req_incr_energy = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   data_type rsp_out_mass, rsp_out_mom_x, rsp_out_mom_y, rsp_out_energy;
   logic csr_valid = 0;
   logic csr_ready;
   logic [GAMMA_W-1:0] csr_heat_ratio = '0;

   logic [GAMMA_W-1:0] gamma_now = HEAT_RATIO_RST;
   face_type pending_faces [$];
   flux_type expected_flux [$];
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   logic hold_rsp = 0;
   int hold_count = 0;
   int errors = 0;
   int cycles = 0;

   euler_flux_split_matvec dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   function automatic longint sat_add(longint a, longint b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s > 65'sd0 + I64_MAX) return I64_MAX;
      if (s < -65'sh1_0000_0000_0000_0000 / 2) return I64_MIN;
      return s[63:0];
   endfunction

   function automatic longint sat_sub(longint a, longint b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s > 65'sd0 + I64_MAX) return I64_MAX;
      if (s < -65'sh1_0000_0000_0000_0000 / 2) return I64_MIN;
      return s[63:0];
   endfunction

   function automatic longint fx_mul(longint a, longint b);
      logic [63:0] ma, mb;
      logic [127:0] p;
      logic neg;
      neg = (a < 0) != (b < 0);
      ma = a < 0 ? 64'(-a) : 64'(a);
      mb = b < 0 ? 64'(-b) : 64'(b);
      p = ({64'b0, ma} * {64'b0, mb}) >> FRAC_BITS;
      if (p > 128'h7FFF_FFFF_FFFF_FFFF) return neg ? I64_MIN : I64_MAX;
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
   endfunction

   function automatic longint halve(longint x);
      return x / 2;
   endfunction

   function automatic flux_type split_flux(face_type f, logic [GAMMA_W-1:0] g);
      longint gam, gm1, rho, u, v, p, nx, ny, lam, q2, un, theta, h, gnx, gny, gu, gv;
      longint x [4];
      longint a [4][4];
      longint s, y;
      logic [127:0] num, quo;
      logic [63:0] den;
      flux_type r;
      gam = longint'(g);
      gm1 = gam - Q_ONE;
      if (gm1 < 1) gm1 = 1;
      rho = longint'(f.density);
      if (rho < 1) rho = 1;
      u = longint'(f.vel_x); v = longint'(f.vel_y); p = longint'(f.pressure);
      nx = longint'(f.normal_x); ny = longint'(f.normal_y);
      lam = longint'(f.spectral_radius);
      for (int i = 0; i < 4; i++) x[i] = longint'(f.incr[i]);
      q2 = sat_add(fx_mul(u, u), fx_mul(v, v));
      un = sat_add(fx_mul(u, nx), fx_mul(v, ny));
      theta = halve(fx_mul(gm1, q2));
      num = ({64'b0, 64'(gam)} * {64'b0, 64'(p)}) << FRAC_BITS;
      den = 64'(gm1) * 64'(rho);
      quo = num / {64'b0, den};
      h = sat_add(quo > 128'h7FFF_FFFF_FFFF_FFFF ? I64_MAX : longint'(quo[63:0]),
                  halve(q2));
      gnx = fx_mul(nx, gm1);
      gny = fx_mul(ny, gm1);
      gu = fx_mul(gm1, u);
      gv = fx_mul(gm1, v);
      a[0][0] = 0; a[0][1] = nx; a[0][2] = ny; a[0][3] = 0;
      a[1][0] = sat_add(sat_sub(0, fx_mul(u, un)), fx_mul(nx, theta));
      a[1][1] = sat_sub(sat_add(un, fx_mul(u, nx)), fx_mul(gnx, u));
      a[1][2] = sat_sub(fx_mul(u, ny), fx_mul(gnx, v));
      a[1][3] = gnx;
      a[2][0] = sat_add(sat_sub(0, fx_mul(v, un)), fx_mul(ny, theta));
      a[2][1] = sat_sub(fx_mul(v, nx), fx_mul(gny, u));
      a[2][2] = sat_sub(sat_add(un, fx_mul(v, ny)), fx_mul(gny, v));
      a[2][3] = gny;
      a[3][0] = fx_mul(un, sat_sub(theta, h));
      a[3][1] = sat_sub(fx_mul(nx, h), fx_mul(gu, un));
      a[3][2] = sat_sub(fx_mul(ny, h), fx_mul(gv, un));
      a[3][3] = fx_mul(gam, un);
      for (int i = 0; i < 4; i++) begin
         s = 0;
         for (int j = 0; j < 4; j++) s = sat_add(s, fx_mul(a[i][j], x[j]));
         y = halve(f.minus_split ? sat_sub(s, fx_mul(lam, x[i]))
                                 : sat_add(s, fx_mul(lam, x[i])));
         if (y > 64'sh7FFF_FFFF) y = 64'sh7FFF_FFFF;
         if (y < -64'sh8000_0000) y = -64'sh8000_0000;
         r.flux[i] = y[31:0];
      end
      return r;
   endfunction

   // mix of full-range, near-unity and extreme values
   function automatic data_type rand_signed();
      case ($urandom_range(0, 5))
         0, 1: return $urandom;
         2, 3: return $urandom_range(0, 1 << 19) - (1 << 18);
         4: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $urandom_range(0, 1 << 13) - (1 << 12);
      endcase
   endfunction

   function automatic logic [MAG_W-1:0] rand_mag();
      case ($urandom_range(0, 5))
         0, 1: return MAG_W'($urandom);
         2, 3: return MAG_W'($urandom_range(1 << 12, 1 << 19));
         4: return $urandom_range(0, 1) ? 31'h7FFF_FFFF : MAG_W'($urandom_range(0, 1));
         default: return MAG_W'($urandom_range(0, 1 << 14));
      endcase
   endfunction

   function automatic face_type rand_face();
      face_type f;
      f.density = rand_mag();
      f.vel_x = rand_signed();
      f.vel_y = rand_signed();
      f.pressure = rand_mag();
      f.normal_x = rand_signed();
      f.normal_y = rand_signed();
      f.spectral_radius = rand_mag();
      f.minus_split = 1'($urandom_range(0, 1));
      for (int i = 0; i < 4; i++) f.incr[i] = rand_signed();
      return f;
   endfunction

   task automatic report(string what, int k, data_type got, data_type want);
      $display("mismatch %s[%0d]: got %h expected %h", what, k, got, want);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      face_type f;
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && req_ready) begin
            f.density = req_density; f.vel_x = req_vel_x; f.vel_y = req_vel_y;
            f.pressure = req_pressure; f.normal_x = req_normal_x;
            f.normal_y = req_normal_y; f.spectral_radius = req_spectral_radius;
            f.minus_split = req_minus_split;
            f.incr[0] = req_incr_mass; f.incr[1] = req_incr_mom_x;
            f.incr[2] = req_incr_mom_y; f.incr[3] = req_incr_energy;
            expected_flux.push_back(split_flux(f, gamma_now));
         end
         if (!req_valid || req_ready) begin
            if (pending_faces.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               f = pending_faces.pop_front();
               req_density <= f.density; req_vel_x <= f.vel_x; req_vel_y <= f.vel_y;
               req_pressure <= f.pressure; req_normal_x <= f.normal_x;
               req_normal_y <= f.normal_y; req_spectral_radius <= f.spectral_radius;
               req_minus_split <= f.minus_split;
               req_incr_mass <= f.incr[0]; req_incr_mom_x <= f.incr[1];
               req_incr_mom_y <= f.incr[2]; req_incr_energy <= f.incr[3];
               req_valid <= 1;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      flux_type e;
      data_type got [4];
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got[0] = rsp_out_mass; got[1] = rsp_out_mom_x;
            got[2] = rsp_out_mom_y; got[3] = rsp_out_energy;
            if (expected_flux.size() == 0) begin
               $display("unexpected result word %h %h %h %h",
                        got[0], got[1], got[2], got[3]);
               errors++;
            end else begin
               e = expected_flux.pop_front();
               for (int k = 0; k < 4; k++)
                  if (got[k] !== e.flux[k]) report("flux", k, got[k], e.flux[k]);
            end
         end
         rsp_ready <= !hold_rsp && $urandom_range(0, 99) >= recv_stall_pct;
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_rsp) begin
         hold_count <= hold_count + 1;
         if (hold_count == HOLD_CYCLES) begin
            hold_rsp <= 0;
         end
      end else begin
         hold_count <= 0;
      end
   end

   // csr write acceptance
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) begin
         gamma_now <= csr_heat_ratio;
         csr_valid <= 0;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout");
         $display("euler_flux_split_matvec_test failed");
         $finish;
      end
   end

   task automatic wait_idle();
      wait (pending_faces.size() == 0 && !req_valid && expected_flux.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_gamma(logic [GAMMA_W-1:0] g);
      @(posedge clock);
      csr_heat_ratio <= g;
      csr_valid <= 1;
      @(posedge clock);
      wait (!csr_valid);
   endtask

   initial begin
      face_type f;
      logic [GAMMA_W-1:0] gammas [7];
      gammas = '{HEAT_RATIO_RST, 18'd65537, 18'd196608, 18'd0,
                 18'h3FFFF, 18'd65536, HEAT_RATIO_RST};
      repeat (6) @(posedge clock);
      reset <= 0;

      // directed words
      for (int d = 0; d < 20; d++) begin
         f.density = 31'd65536; f.vel_x = 32'sd65536; f.vel_y = -32'sd32768;
         f.pressure = 31'd65536; f.normal_x = 32'sd65536; f.normal_y = '0;
         f.spectral_radius = 31'd131072; f.minus_split = d[0];
         for (int i = 0; i < 4; i++) f.incr[i] = 32'sd65536 * (i + 1);
         case (d)
            0, 1: ;
            2: f.density = '0;
            3: f.density = 31'd1;
            4: f.density = 31'h7FFF_FFFF;
            5: begin f.vel_x = 32'h7FFF_FFFF; f.vel_y = 32'h7FFF_FFFF; end
            6: begin f.vel_x = 32'h8000_0000; f.vel_y = 32'h8000_0000; end
            7: f.pressure = 31'h7FFF_FFFF;
            8: f.pressure = '0;
            9, 10: f.spectral_radius = 31'h7FFF_FFFF;
            11: f.spectral_radius = '0;
            12: begin f.normal_x = 32'h8000_0000; f.normal_y = 32'h7FFF_FFFF; end
            13: for (int i = 0; i < 4; i++) f.incr[i] = 32'h7FFF_FFFF;
            14: for (int i = 0; i < 4; i++) f.incr[i] = 32'h8000_0000;
            15: for (int i = 0; i < 4; i++) f.incr[i] = '0;
            16: begin f.density = 31'd1; f.pressure = 31'h7FFF_FFFF; end
            default: f = rand_face();
         endcase
         pending_faces.push_back(f);
      end
      wait_idle();

      for (int ph = 0; ph < 7; ph++) begin
         if (ph != 0) write_gamma(gammas[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
         endcase
         if (ph == 3) hold_rsp = 1;
         for (int n = 0; n < 270; n++) pending_faces.push_back(rand_face());
         wait_idle();
      end

      if (errors == 0) begin
         $display("euler_flux_split_matvec_test passed");
      end else begin
         $display("euler_flux_split_matvec_test failed");
      end
      $finish;
   end

endmodule
